// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MDCF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define MDCF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define MDCF_ASSERT(lbl, clk, rst_n, prop)
`define MDCF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- hdl/mdcf_pkg.sv -----
// ----------------------------------------------------------------------------
// mdcf_pkg
// Shared widths, defaults, register indexes and word types of the
// multichannel dual moving-average filter.
// ----------------------------------------------------------------------------
package mdcf_pkg;

  localparam int unsigned CH_W            = 3;
  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned SUM_W           = 28;
  localparam int unsigned SHIFT_W         = 4;
  localparam int unsigned MASK_W          = 8;
  localparam int unsigned TABLE_W         = 32;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam int unsigned CHANNELS_DEF    = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_VALUE = 2'd0,
    CFG_OFFSET_MASK  = 2'd1,
    CFG_SHIFT_FAST   = 2'd2,
    CFG_SHIFT_SLOW   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } mdcf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] corrected_sample;
    logic [SAMPLE_W-1:0] fast_average;
    logic [SAMPLE_W-1:0] slow_average;
  } mdcf_out_t;

endpackage

// ----- hdl/mdcf_in_if.sv -----
// ----------------------------------------------------------------------------
// mdcf_in_if
// Sample channel: valid/ready handshake with channel number and sample.
// ----------------------------------------------------------------------------
interface mdcf_in_if
  import mdcf_pkg::*;
();

  logic     valid;
  logic     ready;
  mdcf_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- hdl/mdcf_out_if.sv -----
// ----------------------------------------------------------------------------
// mdcf_out_if
// Result channel: valid/ready handshake with corrected sample and averages.
// ----------------------------------------------------------------------------
interface mdcf_out_if
  import mdcf_pkg::*;
();

  logic      valid;
  logic      ready;
  mdcf_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- hdl/mdcf_offset.sv -----
// ----------------------------------------------------------------------------
// mdcf_offset
// Sample range clamp and per-channel offset removal with zero floor.
// ----------------------------------------------------------------------------
module mdcf_offset
  import mdcf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [CH_W-1:0]     channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] offset_value_i,
  input  logic [MASK_W-1:0]   offset_mask_i,
  output logic [SAMPLE_W-1:0] sample_o
);

  localparam logic [SAMPLE_W-1:0] SAT_LIMIT = (SAMPLE_BITS >= SAMPLE_W) ?
                                              {SAMPLE_W{1'b1}} :
                                              SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  logic [SAMPLE_W-1:0] clamped;

  always_comb begin
    clamped = (sample_i > SAT_LIMIT) ? SAT_LIMIT : sample_i;
    if (offset_mask_i[channel_i]) begin
      sample_o = (clamped >= offset_value_i) ? (clamped - offset_value_i) : '0;
    end else begin
      sample_o = clamped;
    end
  end

endmodule

// ----- hdl/mdcf_filter.sv -----
// ----------------------------------------------------------------------------
// mdcf_filter
// One bank of per-channel accumulator filters: sum += x - avg, avg = sum >> k.
// ----------------------------------------------------------------------------
module mdcf_filter
  import mdcf_pkg::*;
#(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_i,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SHIFT_W-1:0]  shift_i,
  output logic [SAMPLE_W-1:0] avg_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AVG_W = SAMPLE_BITS;
  localparam logic [SUM_W-1:0] AVG_MAX = SUM_W'((1 << SAMPLE_BITS) - 1);

  logic [SUM_W-1:0] sum_q [CHANNELS];
  logic [AVG_W-1:0] avg_q [CHANNELS];

  logic             ch_ok;
  logic [IDX_W-1:0] idx;
  logic [SUM_W:0]   total;
  logic [SUM_W:0]   avg_ext;
  logic [SUM_W:0]   diff;
  logic [SUM_W-1:0] sum_d;
  logic [SUM_W-1:0] shifted;
  logic [AVG_W-1:0] avg_d;

  always_comb begin
    ch_ok   = ({1'b0, channel_i} < (CH_W + 1)'(CHANNELS));
    idx     = channel_i[IDX_W-1:0];
    total   = {1'b0, sum_q[idx]} + (SUM_W + 1)'(sample_i);
    avg_ext = (SUM_W + 1)'(avg_q[idx]);
    diff    = (total >= avg_ext) ? (total - avg_ext) : '0;
    sum_d   = diff[SUM_W] ? {SUM_W{1'b1}} : diff[SUM_W-1:0];
    shifted = sum_d >> shift_i;
    avg_d   = (shifted > AVG_MAX) ? AVG_MAX[AVG_W-1:0] : shifted[AVG_W-1:0];
    avg_o   = ch_ok ? SAMPLE_W'(avg_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
        avg_q[i] <= '0;
      end
    end else if (upd_i && ch_ok) begin
      sum_q[idx] <= sum_d;
      avg_q[idx] <= avg_d;
    end
  end

endmodule

// ----- hdl/multichannel_dual_cma_filter_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_dual_cma_filter_top
// Takes one converter sample word per cycle while results are taken, and
// returns one result word per sample: the sample is registered, then offset
// removal and both filter updates of its channel run as one read-modify-write
// on per-channel flip-flop state into the result register. Since the state
// is written back as the result is registered, a sample of the same channel
// may follow in the very next cycle, sustaining one word per cycle. The input
// stays ready while a result waits, until the input and result registers fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multichannel_dual_cma_filter_top
  import mdcf_pkg::*;
#(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mdcf_in_if.sink               in_i,
  mdcf_out_if.source            out_o
);

  logic [SAMPLE_W-1:0] offset_value_q;
  logic [MASK_W-1:0]   offset_mask_q;
  logic [TABLE_W-1:0]  shift_fast_q;
  logic [TABLE_W-1:0]  shift_slow_q;

  logic      s1_valid_q;
  mdcf_in_t  s1_data_q;
  logic      out_valid_q;
  mdcf_out_t out_data_q;
  mdcf_out_t out_data_d;

  logic                out_free;
  logic                s1_adv;
  logic                s1_ready;
  logic [SAMPLE_W-1:0] corrected;
  logic [SHIFT_W-1:0]  fast_shift;
  logic [SHIFT_W-1:0]  slow_shift;
  logic [SAMPLE_W-1:0] fast_avg;
  logic [SAMPLE_W-1:0] slow_avg;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign s1_ready = !s1_valid_q || out_free;

  assign in_i.ready    = s1_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_value_q <= '0;
      offset_mask_q  <= '0;
      shift_fast_q   <= '0;
      shift_slow_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_OFFSET_VALUE: offset_value_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_OFFSET_MASK:  offset_mask_q  <= cfg_data_i[MASK_W-1:0];
        CFG_SHIFT_FAST:   shift_fast_q   <= cfg_data_i[TABLE_W-1:0];
        CFG_SHIFT_SLOW:   shift_slow_q   <= cfg_data_i[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      s1_data_q <= in_i.payload;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign fast_shift = shift_fast_q[{s1_data_q.channel, 2'b00} +: SHIFT_W];
  assign slow_shift = shift_slow_q[{s1_data_q.channel, 2'b00} +: SHIFT_W];

  mdcf_offset #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_offset (
    .channel_i      (s1_data_q.channel),
    .sample_i       (s1_data_q.sample),
    .offset_value_i (offset_value_q),
    .offset_mask_i  (offset_mask_q),
    .sample_o       (corrected)
  );

  mdcf_filter #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_fast (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (s1_adv),
    .channel_i (s1_data_q.channel),
    .sample_i  (corrected),
    .shift_i   (fast_shift),
    .avg_o     (fast_avg)
  );

  mdcf_filter #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_slow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (s1_adv),
    .channel_i (s1_data_q.channel),
    .sample_i  (corrected),
    .shift_i   (slow_shift),
    .avg_o     (slow_avg)
  );

  always_comb begin
    out_data_d.out_channel      = s1_data_q.channel;
    out_data_d.corrected_sample = corrected;
    out_data_d.fast_average     = fast_avg;
    out_data_d.slow_average     = slow_avg;
  end

  `MDCF_ASSERT(a_adv_fills_out, clk_i, rst_ni, s1_adv |=> out_valid_q)

  `MDCF_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                     in_i.valid && in_i.ready && s1_valid_q && !s1_adv)

  `MDCF_ASSERT(a_idle_channel_zero, clk_i, rst_ni,
               (out_valid_q && ({1'b0, out_data_q.out_channel} >= (CH_W + 1)'(CHANNELS)))
               |-> (out_data_q.fast_average == '0 && out_data_q.slow_average == '0))

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel dual moving-average filter. It
// drives sample words with random gaps and holds off results at random. A
// long stall fills the block. An in-bench model tracks both filters of every
// channel and compares each result word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mdcf_pkg::*;

  localparam int unsigned STALL_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_WORDS    = 160;
  localparam logic [31:0] SUM_CEIL       = (32'd1 << SUM_W) - 32'd1;
  localparam logic [31:0] AVG_CEIL       = (32'd1 << SAMPLE_BITS_DEF) - 32'd1;

  typedef struct packed {
    logic [31:0]         sum;
    logic [SAMPLE_W-1:0] avg;
  } ema_state_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mdcf_in_if  in_if ();
  mdcf_out_if out_if ();

  multichannel_dual_cma_filter_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic [SAMPLE_W-1:0] offset_cfg;
  logic [MASK_W-1:0]   mask_cfg;
  logic [TABLE_W-1:0]  fast_shift_cfg;
  logic [TABLE_W-1:0]  slow_shift_cfg;
  logic [31:0]         fast_sum_m [CHANNELS_DEF];
  logic [31:0]         slow_sum_m [CHANNELS_DEF];
  logic [SAMPLE_W-1:0] fast_avg_m [CHANNELS_DEF];
  logic [SAMPLE_W-1:0] slow_avg_m [CHANNELS_DEF];

  mdcf_out_t   expected_results [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned hold_left;
  logic        idle_on;
  logic [CH_W-1:0] last_ch;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic ema_state_t ema_next(input ema_state_t cur, input logic [SAMPLE_W-1:0] x,
                                          input logic [SHIFT_W-1:0] sh);
    ema_state_t nxt;
    logic [31:0] s;
    logic [31:0] a;
    s = cur.sum + 32'(x);
    s = (s >= 32'(cur.avg)) ? s - 32'(cur.avg) : 32'd0;
    if (s > SUM_CEIL) s = SUM_CEIL;
    a = s >> sh;
    if (a > AVG_CEIL) a = AVG_CEIL;
    nxt.sum = s;
    nxt.avg = a[SAMPLE_W-1:0];
    return nxt;
  endfunction

  function automatic mdcf_out_t filter_predict(input mdcf_in_t w);
    mdcf_out_t  res;
    ema_state_t f;
    ema_state_t s;
    logic [SAMPLE_W-1:0] x;
    x = w.sample;
    if (mask_cfg[w.channel]) x = (x >= offset_cfg) ? x - offset_cfg : '0;
    res.out_channel      = w.channel;
    res.corrected_sample = x;
    res.fast_average     = '0;
    res.slow_average     = '0;
    if (int'(w.channel) < CHANNELS_DEF) begin
      f = ema_next({fast_sum_m[w.channel], fast_avg_m[w.channel]}, x,
                   fast_shift_cfg[4*w.channel +: 4]);
      s = ema_next({slow_sum_m[w.channel], slow_avg_m[w.channel]}, x,
                   slow_shift_cfg[4*w.channel +: 4]);
      fast_sum_m[w.channel] = f.sum;
      fast_avg_m[w.channel] = f.avg;
      slow_sum_m[w.channel] = s.sum;
      slow_avg_m[w.channel] = s.avg;
      res.fast_average = f.avg;
      res.slow_average = s.avg;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input mdcf_out_t got);
    mdcf_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected word, channel", got.out_channel, 0);
    end else begin
      want = expected_results.pop_front();
      if (got.out_channel != want.out_channel)
        report_mismatch("out_channel", got.out_channel, want.out_channel);
      if (got.corrected_sample != want.corrected_sample)
        report_mismatch("corrected_sample", got.corrected_sample, want.corrected_sample);
      if (got.fast_average != want.fast_average)
        report_mismatch("fast_average", got.fast_average, want.fast_average);
      if (got.slow_average != want.slow_average)
        report_mismatch("slow_average", got.slow_average, want.slow_average);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result(out_if.payload);
      if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        hold_left    <= STALL_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(0, 99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** multichannel_dual_cma_filter_top: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    mdcf_in_t w;
    w.channel = ch;
    w.sample  = smp;
    while (idle_on && $urandom_range(0, 99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(filter_predict(w));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] ofs, input logic [31:0] msk,
                              input logic [31:0] fsh, input logic [31:0] ssh);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_OFFSET_VALUE;
    cfg_data <= ofs;
    @(posedge clk);
    cfg_idx  <= CFG_OFFSET_MASK;
    cfg_data <= msk;
    @(posedge clk);
    cfg_idx  <= CFG_SHIFT_FAST;
    cfg_data <= fsh;
    @(posedge clk);
    cfg_idx  <= CFG_SHIFT_SLOW;
    cfg_data <= ssh;
    @(posedge clk);
    cfg_we   <= 1'b0;
    offset_cfg     = ofs[SAMPLE_W-1:0];
    mask_cfg       = msk[MASK_W-1:0];
    fast_shift_cfg = fsh;
    slow_shift_cfg = ssh;
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned r;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] smp;
    repeat (count) begin
      ch = ($urandom_range(0, 99) < 30) ? last_ch : CH_W'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 12)      smp = '0;
      else if (r < 24) smp = '1;
      else if (r < 34) smp = offset_cfg + SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
      else             smp = SAMPLE_W'($urandom);
      last_ch = ch;
      send_word(ch, smp);
    end
  endtask

  task automatic test_reset_state();
    send_word(3'd0, 12'h000);
    send_word(3'd7, 12'hFFF);
    send_word(3'd3, 12'hAAA);
    send_word(3'd4, 12'h555);
  endtask

  task automatic test_offset_clamp();
    program_regs(32'hFFFF_F800, 32'hFFFF_FFA5, 32'hF0F0_F00F, 32'h0F0F_0FF0);
    send_word(3'd0, 12'h7FF);
    send_word(3'd0, 12'h800);
    send_word(3'd0, 12'hFFF);
    send_word(3'd1, 12'h7FF);
    send_word(3'd7, 12'h000);
    program_regs(32'h0000_0FFF, 32'h0000_00FF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(3'd2, 12'hFFE);
    send_word(3'd2, 12'hFFF);
    program_regs(32'h0000_0000, 32'h0000_00FF, 32'h1234_5678, 32'h9ABC_DEF0);
    send_word(3'd5, 12'h001);
  endtask

  task automatic test_average_saturation();
    program_regs(32'h0, 32'h0, 32'h0000_000F, 32'h0);
    repeat (6) send_word(3'd0, 12'hFFF);
    program_regs(32'h0, 32'h0, 32'h0, 32'h0);
    send_word(3'd0, 12'h000);
    send_word(3'd0, 12'h000);
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_regs(32'h0, 32'h0, 32'h0, 32'h0);
        1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: program_regs($urandom, $urandom, 32'h3333_3333, 32'h8888_8888);
        default: program_regs($urandom, $urandom, $urandom, $urandom);
      endcase
      send_random(PHASE_WORDS);
    end
  endtask

  task automatic test_no_idle();
    program_regs($urandom, $urandom, $urandom, $urandom);
    idle_on <= 1'b0;
    send_random(150);
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    program_regs($urandom, $urandom, $urandom, $urandom);
    hold_req <= hold_req + 1;
    send_random(60);
    wait_drained();
    send_random(40);
  endtask

  initial begin
    clk            = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_OFFSET_VALUE;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    offset_cfg     = '0;
    mask_cfg       = '0;
    fast_shift_cfg = '0;
    slow_shift_cfg = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    hold_req       = 0;
    hold_ack       = 0;
    hold_left      = 0;
    idle_on        = 1'b1;
    last_ch        = '0;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      fast_sum_m[c] = '0;
      slow_sum_m[c] = '0;
      fast_avg_m[c] = '0;
      slow_avg_m[c] = '0;
    end
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_offset_clamp();
    test_average_saturation();
    test_random_configs();
    test_no_idle();
    test_backpressure();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("** multichannel_dual_cma_filter_top: PASSED **");
    else
      $display("** multichannel_dual_cma_filter_top: FAILED **");
    $finish;
  end

endmodule
